FILE: sv/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg: shared types and constants of the state-space step unit
// Item and result structs, sequencer codes and the control bundle that the
// sequencer broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package vss_pkg;

    // Payload lanes are fixed at four latent and two covariate fields.
    localparam int LANES = 4;
    localparam int K_W   = 2;
    localparam int CNT_W = 16;
    localparam int STEP_W = 18;

    localparam logic [1:0] CFG_BURN_IN    = 2'd0;
    localparam logic [1:0] CFG_KEPT_STEPS = 2'd1;

    typedef logic signed [31:0] t_q;

    typedef enum logic [1:0] {
        KIND_COEF = 2'd0,
        KIND_INIT = 2'd1,
        KIND_STEP = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TBL_MEAN = 3'd0,
        TBL_INIT = 3'd1,
        TBL_ICPT = 3'd2,
        TBL_TRAN = 3'd3,
        TBL_NOIS = 3'd4,
        TBL_GAIN = 3'd5
    } t_table;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_BIAS,
        PH_TRAN,
        PH_NOIS,
        PH_GAIN
    } t_phase;

    typedef enum logic [1:0] {
        RING_HOLD,
        RING_STATE,
        RING_NOISE,
        RING_SHIFT
    } t_ring_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] table_select;
        logic [1:0] row_index;
        logic [1:0] col_index;
        t_q         coef_value;
        t_q         noise_0;
        t_q         noise_1;
        t_q         noise_2;
        t_q         noise_3;
        t_q         covar_0;
        t_q         covar_1;
    } t_in_item;

    typedef struct packed {
        t_q               latent_0;
        t_q               latent_1;
        t_q               latent_2;
        t_q               latent_3;
        logic [CNT_W-1:0] step_number;
        logic             is_last;
    } t_out_item;

    typedef struct packed {
        logic           issue;
        logic           init;
        t_phase         phase;
        logic [K_W-1:0] k;
        logic           last;
        t_ring_cmd      ring;
    } t_cell_ctl;

    typedef struct packed {
        logic       en;
        logic [2:0] table_select;
        logic [1:0] row_index;
        logic [1:0] col_index;
        t_q         value;
    } t_coef_wr;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] step_number;
        logic             is_last;
    } t_emit;

endpackage

FILE: sv/vss_cell.sv
// ----------------------------------------------------------------------------
// vss_cell: one latent row of the state-space step unit
// Holds the coefficients of its row, its state element and one ring register
// that passes state and noise values to the neighboring cell on a shift command.
// ----------------------------------------------------------------------------
module vss_cell
    import vss_pkg::*;
#(
    parameter int LATENT_COUNT    = 4,
    parameter int COVARIATE_COUNT = 2,
    parameter int FRAC_BITS       = 16,
    parameter int CELL_IDX        = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_coef_wr  i_wr,
    input  t_in_item  i_item,
    input  t_q        i_ring,
    output t_q        o_ring,
    output t_q        o_latent
);

    localparam int CELL_DEPTH = 2 + 3 * LATENT_COUNT + COVARIATE_COUNT;
    localparam int AW         = $clog2(CELL_DEPTH);
    localparam int ACC_W      = 68 - FRAC_BITS;

    localparam logic [AW-1:0] A_MEAN = AW'(0);
    localparam logic [AW-1:0] A_ICPT = AW'(1);
    localparam logic [AW-1:0] A_INIT = AW'(2);
    localparam logic [AW-1:0] A_TRAN = AW'(2 + LATENT_COUNT);
    localparam logic [AW-1:0] A_NOIS = AW'(2 + 2 * LATENT_COUNT);
    localparam logic [AW-1:0] A_GAIN = AW'(2 + 3 * LATENT_COUNT);

    localparam logic [2:0] L3   = 3'(LATENT_COUNT);
    localparam logic [2:0] C3   = 3'(COVARIATE_COUNT);
    localparam logic [2:0] IDX3 = 3'(CELL_IDX);
    localparam logic [1:0] IDX2 = 2'(CELL_IDX);

    function automatic t_q noise_lane(input t_in_item it, input logic [1:0] idx);
        t_q v;
        case (idx)
            2'd0:    v = it.noise_0;
            2'd1:    v = it.noise_1;
            2'd2:    v = it.noise_2;
            2'd3:    v = it.noise_3;
            default: v = it.noise_0;
        endcase
        return v;
    endfunction

    function automatic t_q covar_lane(input t_in_item it, input logic idx);
        t_q v;
        case (idx)
            1'b0:    v = it.covar_0;
            1'b1:    v = it.covar_1;
            default: v = it.covar_0;
        endcase
        return v;
    endfunction

    t_q mem [CELL_DEPTH];

    logic                    w_wr_ok;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic [AW-1:0]           w_rd_addr;
    logic [2:0]              w_col_sum;
    logic [1:0]              w_col;
    t_q                      w_op;
    logic signed [63:0]      w_prod;
    logic signed [63:0]      w_shift;
    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_sum;
    logic [ACC_W-32:0]       w_hi;
    t_q                      w_sat;

    t_q                      r_ring;
    t_q                      r_lat;
    t_q                      r_rd;
    t_q                      r_op;
    logic                    r_v1;
    logic                    r_bias1;
    logic                    r_last1;
    logic signed [ACC_W-1:0] r_term;
    logic                    r_v2;
    logic                    r_first2;
    logic                    r_last2;
    logic signed [ACC_W-1:0] r_acc;

    // Coefficient write decode; only the row owned by this cell is taken.
    always_comb begin
        w_wr_ok   = 1'b0;
        w_wr_addr = A_MEAN;
        case (i_wr.table_select)
            TBL_MEAN: begin
                w_wr_ok   = 1'b1;
                w_wr_addr = A_MEAN;
            end
            TBL_ICPT: begin
                w_wr_ok   = 1'b1;
                w_wr_addr = A_ICPT;
            end
            TBL_INIT: begin
                w_wr_ok   = {1'b0, i_wr.col_index} < L3;
                w_wr_addr = A_INIT + AW'(i_wr.col_index);
            end
            TBL_TRAN: begin
                w_wr_ok   = {1'b0, i_wr.col_index} < L3;
                w_wr_addr = A_TRAN + AW'(i_wr.col_index);
            end
            TBL_NOIS: begin
                w_wr_ok   = {1'b0, i_wr.col_index} < L3;
                w_wr_addr = A_NOIS + AW'(i_wr.col_index);
            end
            TBL_GAIN: begin
                w_wr_ok   = {1'b0, i_wr.col_index} < C3;
                w_wr_addr = A_GAIN + AW'(i_wr.col_index);
            end
            default: begin
                w_wr_ok   = 1'b0;
                w_wr_addr = A_MEAN;
            end
        endcase
        w_wr_en = i_wr.en && (i_wr.row_index == IDX2) && w_wr_ok;
    end

    // The ring register of this cell holds column (CELL_IDX + k) mod LATENT_COUNT.
    always_comb begin
        w_col_sum = {1'b0, i_ctl.k} + IDX3;
        w_col     = (w_col_sum >= L3) ? 2'(w_col_sum - L3) : w_col_sum[1:0];
        case (i_ctl.phase)
            PH_BIAS: w_rd_addr = i_ctl.init ? A_MEAN : A_ICPT;
            PH_TRAN: w_rd_addr = A_TRAN + AW'(w_col);
            PH_NOIS: w_rd_addr = (i_ctl.init ? A_INIT : A_NOIS) + AW'(w_col);
            PH_GAIN: w_rd_addr = A_GAIN + AW'(i_ctl.k);
            default: w_rd_addr = A_MEAN;
        endcase
        w_op = (i_ctl.phase == PH_GAIN) ? covar_lane(i_item, i_ctl.k[0]) : r_ring;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_wr.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_rd <= mem[w_rd_addr];
            r_op <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.ring)
            RING_STATE: r_ring <= r_lat;
            RING_NOISE: r_ring <= noise_lane(i_item, IDX2);
            RING_SHIFT: r_ring <= i_ring;
            default:    r_ring <= r_ring;
        endcase
    end

    // Products drop the fraction bits toward minus infinity; the bias term
    // enters the sum as it is.
    always_comb begin
        w_prod  = r_rd * r_op;
        w_shift = w_prod >>> FRAC_BITS;
        w_term  = r_bias1 ? {{(ACC_W - 32){r_rd[31]}}, r_rd} : w_shift[ACC_W-1:0];
    end

    always_comb begin
        w_sum = r_first2 ? r_term : r_acc + r_term;
        w_hi  = w_sum[ACC_W-1:31];
        if ((&w_hi) || !(|w_hi)) begin
            w_sat = w_sum[31:0];
        end else if (w_sum[ACC_W-1]) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= w_term;
        if (r_v2) begin
            r_acc <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_bias1  <= 1'b0;
            r_last1  <= 1'b0;
            r_v2     <= 1'b0;
            r_first2 <= 1'b0;
            r_last2  <= 1'b0;
            r_lat    <= '0;
        end else begin
            r_v1     <= i_ctl.issue;
            r_bias1  <= i_ctl.issue && (i_ctl.phase == PH_BIAS);
            r_last1  <= i_ctl.issue && i_ctl.last;
            r_v2     <= r_v1;
            r_first2 <= r_bias1;
            r_last2  <= r_last1;
            if (r_v2 && r_last2) begin
                r_lat <= w_sat;
            end
        end
    end

    assign o_ring   = r_ring;
    assign o_latent = r_lat;

endmodule

FILE: sv/vss_ctrl.sv
// ----------------------------------------------------------------------------
// vss_ctrl: sequencer of the state-space step unit
// Accepts items, keeps the step counter and the run registers, and walks the
// cells through bias, transition (regular steps only), noise and covariate terms of one step.
// ----------------------------------------------------------------------------
module vss_ctrl
    import vss_pkg::*;
#(
    parameter int LATENT_COUNT    = 4,
    parameter int COVARIATE_COUNT = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_out_free,
    output t_cell_ctl        o_ctl,
    output t_coef_wr         o_wr,
    output t_in_item         o_item,
    output t_emit            o_emit
);

    localparam logic [K_W-1:0] K_LAST_L = K_W'(LATENT_COUNT - 1);
    localparam logic [K_W-1:0] K_LAST_C = K_W'(COVARIATE_COUNT - 1);
    localparam logic [2:0]     C3       = 3'(COVARIATE_COUNT);

    t_state            r_state;
    t_state            n_state;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [K_W-1:0]    r_k;
    logic [K_W-1:0]    n_k;
    logic              r_init;
    logic              r_emit;
    logic [STEP_W-1:0] r_step_count;
    logic [CNT_W-1:0]  r_burn;
    logic [CNT_W-1:0]  r_kept;
    logic [CNT_W-1:0]  r_step_num;
    logic              r_last;
    t_in_item          r_item;

    logic              w_acc;
    logic              w_is_init;
    logic              w_run;
    logic [STEP_W-1:0] w_t;
    logic [STEP_W-1:0] w_total;
    logic [STEP_W-1:0] w_diff;

    always_comb begin
        w_acc     = i_in_valid && (r_state == ST_IDLE);
        w_is_init = (i_in_data.kind == KIND_INIT);
        w_t       = w_is_init ? '0 : r_step_count;
        w_total   = STEP_W'(r_burn) + STEP_W'(r_kept);
        w_diff    = w_t - STEP_W'(r_burn);
        // A regular step past the end of the run is dropped without effect.
        w_run     = w_acc && (w_is_init ||
                              ((i_in_data.kind == KIND_STEP) && (w_t < w_total)));

        o_wr.en           = w_acc && (i_in_data.kind == KIND_COEF);
        o_wr.table_select = i_in_data.table_select;
        o_wr.row_index    = i_in_data.row_index;
        o_wr.col_index    = i_in_data.col_index;
        o_wr.value        = i_in_data.coef_value;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_k     = r_k;

        o_ctl.issue = 1'b0;
        o_ctl.init  = r_init;
        o_ctl.phase = r_phase;
        o_ctl.k     = r_k;
        o_ctl.last  = 1'b0;
        o_ctl.ring  = RING_HOLD;

        o_emit.load        = 1'b0;
        o_emit.step_number = r_step_num;
        o_emit.is_last     = r_last;

        case (r_state)
            ST_IDLE: begin
                if (w_run) begin
                    n_state = ST_RUN;
                    n_phase = PH_BIAS;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                o_ctl.issue = 1'b1;
                // The ring command prepares the operand of the next term.
                case (r_phase)
                    PH_BIAS: begin
                        n_k = '0;
                        if (r_init) begin
                            n_phase    = PH_NOIS;
                            o_ctl.ring = RING_NOISE;
                        end else begin
                            n_phase    = PH_TRAN;
                            o_ctl.ring = RING_STATE;
                        end
                    end
                    PH_TRAN: begin
                        if (r_k == K_LAST_L) begin
                            n_phase    = PH_NOIS;
                            n_k        = '0;
                            o_ctl.ring = RING_NOISE;
                        end else begin
                            n_k        = r_k + 1'b1;
                            o_ctl.ring = RING_SHIFT;
                        end
                    end
                    PH_NOIS: begin
                        if (r_k == K_LAST_L) begin
                            n_phase = PH_GAIN;
                            n_k     = '0;
                        end else begin
                            n_k        = r_k + 1'b1;
                            o_ctl.ring = RING_SHIFT;
                        end
                    end
                    PH_GAIN: begin
                        if (r_k == K_LAST_C) begin
                            o_ctl.last = 1'b1;
                            n_state    = ST_DRAIN1;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_DRAIN1: begin
                n_state = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_emit) begin
                    n_state = ST_IDLE;
                end else if (i_out_free) begin
                    o_emit.load = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_BIAS;
            r_k          <= '0;
            r_init       <= 1'b0;
            r_emit       <= 1'b0;
            r_step_count <= '0;
            r_burn       <= '0;
            r_kept       <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
            if (w_run) begin
                r_step_count <= w_t + 1'b1;
                r_init       <= w_is_init;
                r_emit       <= (w_t >= STEP_W'(r_burn)) && (w_diff < STEP_W'(r_kept));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BURN_IN:    r_burn <= i_cfg_data;
                    CFG_KEPT_STEPS: r_kept <= i_cfg_data;
                    default:        r_burn <= r_burn;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_run) begin
            r_item     <= i_in_data;
            r_step_num <= w_diff[CNT_W-1:0];
            r_last     <= (w_diff == (STEP_W'(r_kept) - 1'b1));
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_item     = r_item;

    a_no_tran_on_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_phase == PH_TRAN) |-> !r_init)
        else $error("transition terms issued on an initial step");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.issue && o_ctl.last) |=> (r_state == ST_DRAIN1))
        else $error("last term not followed by pipeline drain");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.load |-> (r_emit && i_out_free && r_state == ST_EMIT))
        else $error("result loaded without a kept step or a free output");

    a_coef_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |=> (r_state == ST_IDLE))
        else $error("coefficient write started a step");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_phase == PH_GAIN) |-> ({1'b0, r_k} < C3))
        else $error("covariate index out of range");

endmodule

FILE: sv/var1_state_space_step_unit.sv
// ----------------------------------------------------------------------------
// var1_state_space_step_unit: VAR(1) state-space step with covariates, Q16.16
// A new item is taken only while idle, so each step finishes before the next item is accepted.
// Steps are paced by the per-cell multiply-accumulate walking its row; one coefficient write per cycle while idle.
// Reset (synchronous): state and step counter cleared, burn-in 0, kept steps 1; coefficients undefined until written.
// ----------------------------------------------------------------------------
module var1_state_space_step_unit
    import vss_pkg::*;
#(
    parameter int LATENT_COUNT    = 4,
    parameter int COVARIATE_COUNT = 2,
    parameter int FRAC_BITS       = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cell_ctl w_ctl;
    t_coef_wr  w_wr;
    t_in_item  w_item;
    t_emit     w_emit;
    logic      w_cfg_we;
    logic      w_out_free;
    t_q        w_ring [LATENT_COUNT];
    t_q        w_lat  [LANES];

    logic      r_out_valid;
    t_out_item r_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    vss_ctrl #(
        .LATENT_COUNT    (LATENT_COUNT),
        .COVARIATE_COUNT (COVARIATE_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl),
        .o_wr        (w_wr),
        .o_item      (w_item),
        .o_emit      (w_emit)
    );

    // Cells form a ring: each one takes the ring value of the next cell.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < LATENT_COUNT) begin : g_cell
            vss_cell #(
                .LATENT_COUNT    (LATENT_COUNT),
                .COVARIATE_COUNT (COVARIATE_COUNT),
                .FRAC_BITS       (FRAC_BITS),
                .CELL_IDX        (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_wr     (w_wr),
                .i_item   (w_item),
                .i_ring   (w_ring[(g + 1) % LATENT_COUNT]),
                .o_ring   (w_ring[g]),
                .o_latent (w_lat[g])
            );
        end else begin : g_zero
            assign w_lat[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_out.latent_0    <= w_lat[0];
            r_out.latent_1    <= w_lat[1];
            r_out.latent_2    <= w_lat[2];
            r_out.latent_3    <= w_lat[3];
            r_out.step_number <= w_emit.step_number;
            r_out.is_last     <= w_emit.is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/vss_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_step_checker: scoreboard for the state-space step unit
// Watches the item, result and register channels, keeps its own copy of the
// coefficient tables, latent state, step counter and run limits, predicts
// each kept step and compares every result transaction with the oldest one.
// ----------------------------------------------------------------------------
module vss_step_checker
    import vss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int     LATENT_N  = 4;
    localparam int     COVAR_N   = 2;
    localparam int     FRAC      = 16;
    localparam int     MAX_LINES = 200;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;

    t_q                mean_vec  [LATENT_N];
    t_q                init_fac  [LATENT_N][LATENT_N];
    t_q                icpt_vec  [LATENT_N];
    t_q                tran_mat  [LATENT_N][LATENT_N];
    t_q                noise_fac [LATENT_N][LATENT_N];
    t_q                gain_mat  [LATENT_N][COVAR_N];
    t_q                latent    [LATENT_N];
    logic [STEP_W-1:0] step_index;
    logic [CNT_W-1:0]  burn_steps;
    logic [CNT_W-1:0]  kept_steps;
    t_out_item         kept_step_q [$];
    t_out_item         head_result;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    // Exact product with the fraction bits dropped toward minus infinity.
    function automatic longint q_mul(input t_q a, input t_q b);
        return (longint'(a) * longint'(b)) >>> FRAC;
    endfunction

    function automatic t_q q_sat(input longint s);
        if (s > Q_MAX) begin
            return t_q'(Q_MAX);
        end
        if (s < Q_MIN) begin
            return t_q'(Q_MIN);
        end
        return t_q'(s);
    endfunction

    task automatic report_error(input string msg);
        fail_count++;
        // Past this many lines a broken block only repeats itself.
        if (fail_count <= MAX_LINES) begin
            $display("%0t ns  step check: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_error($sformatf("%s got %0d, want %0d (step %0d)",
                                   name, got, want, head_result.step_number));
        end
    endtask

    task automatic store_coef(input t_in_item it);
        case (it.table_select)
            TBL_MEAN: mean_vec[it.row_index] = it.coef_value;
            TBL_INIT: init_fac[it.row_index][it.col_index] = it.coef_value;
            TBL_ICPT: icpt_vec[it.row_index] = it.coef_value;
            TBL_TRAN: tran_mat[it.row_index][it.col_index] = it.coef_value;
            TBL_NOIS: noise_fac[it.row_index][it.col_index] = it.coef_value;
            TBL_GAIN: begin
                if (it.col_index < COVAR_N) begin
                    gain_mat[it.row_index][it.col_index] = it.coef_value;
                end
            end
            default: ;
        endcase
    endtask

    task automatic run_var_step(input t_in_item it);
        logic      from_start;
        int        t;
        int        burn_i;
        int        kept_i;
        int        i;
        int        j;
        longint    acc;
        t_q        noise [LATENT_N];
        t_q        covar [COVAR_N];
        t_q        nxt   [LATENT_N];
        t_out_item res;

        from_start = (it.kind == KIND_INIT);
        burn_i     = int'(burn_steps);
        kept_i     = int'(kept_steps);
        t          = from_start ? 0 : int'(step_index);
        // A regular step beyond the end of the run leaves everything alone.
        if (!from_start && t >= burn_i + kept_i) begin
            return;
        end

        noise[0] = it.noise_0;
        noise[1] = it.noise_1;
        noise[2] = it.noise_2;
        noise[3] = it.noise_3;
        covar[0] = it.covar_0;
        covar[1] = it.covar_1;

        for (i = 0; i < LATENT_N; i++) begin
            acc = from_start ? longint'(mean_vec[i]) : longint'(icpt_vec[i]);
            for (j = 0; j < LATENT_N; j++) begin
                if (from_start) begin
                    acc += q_mul(init_fac[i][j], noise[j]);
                end else begin
                    acc += q_mul(tran_mat[i][j], latent[j]) + q_mul(noise_fac[i][j], noise[j]);
                end
            end
            for (j = 0; j < COVAR_N; j++) begin
                acc += q_mul(gain_mat[i][j], covar[j]);
            end
            nxt[i] = q_sat(acc);
        end
        latent     = nxt;
        step_index = STEP_W'(t + 1);

        if (t < burn_i || t - burn_i >= kept_i) begin
            return;
        end
        res.latent_0    = latent[0];
        res.latent_1    = latent[1];
        res.latent_2    = latent[2];
        res.latent_3    = latent[3];
        res.step_number = CNT_W'(t - burn_i);
        res.is_last     = (t - burn_i == kept_i - 1);
        kept_step_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (latent[i]) begin
                latent[i] = '0;
            end
            step_index = '0;
            burn_steps = '0;
            kept_steps = CNT_W'(1);
            kept_step_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (kept_step_q.size() == 0) begin
                    report_error($sformatf("result transaction for step %0d with none pending",
                                           i_out_data.step_number));
                end else begin
                    head_result = kept_step_q.pop_front();
                    check_field("latent_0", i_out_data.latent_0, head_result.latent_0);
                    check_field("latent_1", i_out_data.latent_1, head_result.latent_1);
                    check_field("latent_2", i_out_data.latent_2, head_result.latent_2);
                    check_field("latent_3", i_out_data.latent_3, head_result.latent_3);
                    check_field("step_number", i_out_data.step_number,
                                head_result.step_number);
                    check_field("is_last", i_out_data.is_last, head_result.is_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BURN_IN:    burn_steps = i_cfg_data;
                    CFG_KEPT_STEPS: kept_steps = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.kind)
                    KIND_COEF: store_coef(i_in_data);
                    KIND_INIT, KIND_STEP: run_var_step(i_in_data);
                    default: ;
                endcase
            end
            o_pending <= kept_step_q.size();
        end
    end

endmodule

FILE: sim/var1_state_space_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// var1_state_space_step_unit_tb: regression for the state-space step unit
// Loads every coefficient, runs a directed set of steps and ignored writes,
// then random initial-plus-regular step runs over several burn-in and kept
// step settings with random sender gaps and receiver stalls. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module var1_state_space_step_unit_tb;
    import vss_pkg::*;

    localparam int         CYCLE_LIMIT   = 400_000;
    localparam int         SETTLE_CYCLES = 32;
    localparam int         RANDOM_ITEMS  = 1350;
    localparam int         PHASE_COUNT   = 7;
    localparam int         LATENT_N      = 4;
    localparam int         COVAR_N       = 2;
    localparam int         MAX_RUN       = 40;
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam logic [2:0] TBL_SPARE_LO  = 3'd6;
    localparam logic [2:0] TBL_SPARE_HI  = 3'd7;
    localparam t_q         Q_MAX         = 32'sh7FFF_FFFF;
    localparam t_q         Q_MIN         = 32'sh8000_0000;
    localparam t_q         Q_ONE         = 32'sd65536;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = '0;
    logic [CNT_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int send_idle_pct  = 23;
    int recv_stall_pct = 60;
    int random_sent    = 0;
    int cycle_count    = 0;

    var1_state_space_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    vss_step_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly samples of a few standard deviations, sometimes the full range.
    function automatic t_q rand_sample();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return t_q'($urandom);
            default: return t_q'($urandom_range(393216)) - 32'sd196608;
        endcase
    endfunction

    function automatic t_q rand_coef();
        case ($urandom_range(19))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return t_q'($urandom);
            default: return t_q'($urandom_range(65536)) - 32'sd32768;
        endcase
    endfunction

    function automatic t_in_item random_item(input logic [1:0] kind);
        t_in_item it;
        it.kind         = kind;
        it.table_select = 3'($urandom_range(7));
        it.row_index    = 2'($urandom_range(3));
        it.col_index    = 2'($urandom_range(3));
        it.coef_value   = t_q'($urandom);
        it.noise_0      = rand_sample();
        it.noise_1      = rand_sample();
        it.noise_2      = rand_sample();
        it.noise_3      = rand_sample();
        it.covar_0      = rand_sample();
        it.covar_1      = rand_sample();
        return it;
    endfunction

    function automatic t_in_item coef_item(input logic [2:0] tbl, input int row, input int col,
                                           input t_q value);
        t_in_item it;
        it              = random_item(KIND_COEF);
        it.table_select = tbl;
        it.row_index    = 2'(row);
        it.col_index    = 2'(col);
        it.coef_value   = value;
        return it;
    endfunction

    // Called at a rising edge; returns at the first edge at which the input is no longer stalled.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_item(input t_in_item it);
        case (random_sent * 3 / RANDOM_ITEMS)
            0: begin
                send_idle_pct = 23;
                recv_stall_pct <= 60;
            end
            1: begin
                send_idle_pct = 60;
                recv_stall_pct <= 23;
            end
            default: begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
        endcase
        send_item(it);
        if (it.kind != KIND_SPARE) begin
            random_sent++;
        end
    endtask

    // Steps that give no result may still be in flight, hence the settle time.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_run_limits(input logic [CNT_W-1:0] burn, input logic [CNT_W-1:0] kept);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BURN_IN;
        i_cfg_data  <= burn;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_KEPT_STEPS;
        i_cfg_data  <= kept;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in_item         it;
        t_table           tbl;
        t_q               value;
        int               row;
        int               col;
        int               cols;
        int               ph;
        int               span;
        int               run_len;
        int               pick;
        int               budget;
        int               phase_end;
        logic [CNT_W-1:0] run_burn;
        logic [CNT_W-1:0] run_kept;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every table entry is written before any step reads it. Square
        // tables lean on the diagonal so the state stays mostly in range.
        tbl = TBL_MEAN;
        do begin
            cols = (tbl == TBL_MEAN || tbl == TBL_ICPT) ? 1 :
                   (tbl == TBL_GAIN) ? COVAR_N : LATENT_N;
            for (row = 0; row < LATENT_N; row++) begin
                for (col = 0; col < cols; col++) begin
                    value = t_q'($urandom_range(32768)) - 32'sd16384;
                    if (row == col && cols == LATENT_N) begin
                        value = value + Q_ONE / 2;
                    end
                    send_item(coef_item(tbl, row, col, value));
                end
            end
            tbl = tbl.next();
        end while (tbl != TBL_MEAN);

        // Reset limits: a regular step with no initial step counts as index
        // zero, and the one after it falls past the one-step run.
        send_item(random_item(KIND_STEP));
        send_item(random_item(KIND_STEP));
        send_item(random_item(KIND_SPARE));
        send_item(coef_item(TBL_SPARE_LO, 0, 0, Q_MAX));
        send_item(coef_item(TBL_SPARE_HI, 3, 3, Q_MIN));
        send_item(coef_item(TBL_GAIN, 1, 2, Q_MAX));
        send_item(coef_item(TBL_GAIN, 2, 3, Q_MIN));
        send_item(coef_item(TBL_MEAN, 2, 3, Q_ONE));
        it = random_item(KIND_INIT);
        {it.noise_0, it.noise_1, it.noise_2, it.noise_3, it.covar_0, it.covar_1} = {6{Q_MAX}};
        send_item(it);
        {it.noise_0, it.noise_1, it.noise_2, it.noise_3, it.covar_0, it.covar_1} = {6{Q_MIN}};
        send_item(it);
        it      = '0;
        it.kind = KIND_INIT;
        send_item(it);

        // Extreme transition terms drive the regular steps into saturation.
        wait_quiet();
        load_run_limits(CNT_W'(0), CNT_W'(4));
        send_item(coef_item(TBL_TRAN, 0, 0, Q_MAX));
        send_item(coef_item(TBL_TRAN, 3, 2, Q_MIN));
        send_item(random_item(KIND_INIT));
        send_item(random_item(KIND_STEP));
        send_item(random_item(KIND_STEP));
        send_item(coef_item(TBL_TRAN, 0, 0, Q_ONE / 2));
        send_item(coef_item(TBL_TRAN, 3, 2, '0));

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    // No kept steps at all: even initial steps stay silent.
                    run_burn = '0;
                    run_kept = '0;
                    budget   = 40;
                end
                1: begin
                    run_burn = CNT_W'(3);
                    run_kept = CNT_W'(5);
                    budget   = 300;
                end
                2: begin
                    run_burn = '0;
                    run_kept = '1;
                    budget   = 300;
                end
                3: begin
                    run_burn = '1;
                    run_kept = '1;
                    budget   = 60;
                end
                4: begin
                    run_burn = CNT_W'(1);
                    run_kept = CNT_W'(1);
                    budget   = 200;
                end
                5: begin
                    run_burn = CNT_W'(5);
                    run_kept = CNT_W'(20);
                    budget   = 300;
                end
                default: begin
                    run_burn = '0;
                    run_kept = CNT_W'(3);
                    budget   = 150;
                end
            endcase
            wait_quiet();
            load_run_limits(run_burn, run_kept);
            phase_end = random_sent + budget;
            // Runs of up to two steps beyond burn-in plus kept steps (capped at
            // MAX_RUN) reach the steps that fall past the end of the run.
            span = int'(run_burn) + int'(run_kept) + 2;
            if (span > MAX_RUN) begin
                span = MAX_RUN;
            end
            while (random_sent < phase_end) begin
                if ($urandom_range(99) < 80) begin
                    push_item(random_item(KIND_INIT));
                    run_len = $urandom_range(span);
                    repeat (run_len) begin
                        pick = $urandom_range(99);
                        if (pick < 8) begin
                            it              = random_item(KIND_COEF);
                            it.table_select = 3'($urandom_range(TBL_GAIN));
                            it.coef_value   = rand_coef();
                            push_item(it);
                        end else if (pick < 11) begin
                            push_item(random_item(KIND_SPARE));
                        end
                        push_item(random_item(KIND_STEP));
                    end
                end else begin
                    push_item(random_item(2'($urandom_range(3))));
                end
            end
        end

        wait_quiet();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
